// ----- sv/tcti_pkg.sv -----
// ============================================================================
// tcti_pkg - shared definitions for the temperature compensation interpolator
// Field widths, stream packing, opcodes, register indexes and point layout.
// ============================================================================
`default_nettype none

package tcti_pkg;

    // Field widths
    localparam int TEMP_W = 16;
    localparam int VOLT_W = 16;
    localparam int CNT_W  = 5;
    localparam int IDX_W  = 4;

    // Configuration channel
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Stream widths
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    // Input kinds (s_tuser[0])
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result status (m_tuser[0])
    localparam logic STATUS_VALID  = 1'b0;
    localparam logic STATUS_NO_SEG = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_CARRIER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PEAK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_FIRST    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_SECOND   = 2'd3;

    localparam logic [VOLT_W-1:0] DEFAULT_VOLT_RESET = 16'd4096;

    // Serial divider: quotient is never wider than one voltage
    localparam int DIV_STEPS = VOLT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef logic        [VOLT_W-1:0] volt_t;
    typedef logic signed [TEMP_W-1:0] temp_t;

    // One table point as stored in the point memory, temperature lowest
    typedef struct packed {
        volt_t peak;
        volt_t carrier;
        temp_t temp;
    } point_t;

    localparam int POINT_W = $bits(point_t);

endpackage : tcti_pkg

`default_nettype wire

// ----- sv/tcti_ram.sv -----
// ============================================================================
// tcti_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module tcti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : tcti_ram

`default_nettype wire

// ----- sv/temp_comp_table_interpolator_unit.sv -----
// ============================================================================
// temp_comp_table_interpolator_unit - two-unit temperature compensation lookup
// Piecewise-linear interpolation of carrier and peak voltage over a table.
// ============================================================================
// Holds one table of up to MAX_POINTS points per unit in a single point
// memory. A write transaction (s_tuser[0] = 0) stores one point and returns
// nothing; an index at or above MAX_POINTS is dropped. A query
// transaction (s_tuser[0] = 1) returns one result: defaults for an empty
// table, the end point outside the table, else the interpolated voltages of
// the first bracketing segment, or status 1 when none brackets. During a
// query the walk reads one point per cycle from the memory's single read port,
// and each interpolation runs the shared 16x16 multiplier once and then a
// 16-step restoring divider, first for carrier and then for peak. The block
// takes no input while a query is in progress; a finished result waits in
// the output register. Points must be written before they are queried.
`default_nettype none

module temp_comp_table_interpolator_unit #(
    parameter int MAX_POINTS = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tcti_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tcti_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [3:0] point_index, [19:4] temperature, [35:20] carrier_in, [51:36] peak_in
    input  wire logic [tcti_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] opcode, [1] unit_select
    input  wire logic [tcti_pkg::S_TUSER_W-1:0]  s_tuser,
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [15:0] carrier_out, [31:16] peak_out
    output logic      [tcti_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] status
    output logic      [tcti_pkg::M_TUSER_W-1:0]  m_tuser
);

    import tcti_pkg::*;

    localparam int IW    = $clog2(MAX_POINTS);
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK0 = 3'd1;  // point 0 on read data
    localparam logic [2:0] S_CHKL = 3'd2;  // last point on read data
    localparam logic [2:0] S_WALK = 3'd3;  // one segment per cycle
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // Input fields
    logic             in_op;
    logic             in_unit;
    logic [IDX_W-1:0] in_idx;
    point_t           in_point;

    assign in_op            = s_tuser[0];
    assign in_unit          = s_tuser[1];
    assign in_idx           = s_tdata[3:0];
    assign in_point.temp    = s_tdata[19:4];
    assign in_point.carrier = s_tdata[35:20];
    assign in_point.peak    = s_tdata[51:36];

    // Control registers
    logic [2:0]           state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    volt_t                dflt_carrier_reg, dflt_carrier_next;
    volt_t                dflt_peak_reg, dflt_peak_next;
    logic [CNT_W-1:0]     pts_first_reg, pts_first_next;
    logic [CNT_W-1:0]     pts_second_reg, pts_second_next;
    logic                 lane_reg, lane_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // Payload registers
    logic             unit_reg, unit_next;
    temp_t            temp_reg, temp_next;
    logic [IW-1:0]    last_reg, last_next;
    logic [IW-1:0]    pos_reg, pos_next;
    point_t           prev_reg, prev_next;
    point_t           cur_reg, cur_next;
    volt_t            dt_reg, dt_next;
    volt_t            span_reg, span_next;
    logic             neg_reg, neg_next;
    volt_t            rem_reg, rem_next;
    volt_t            dvd_reg, dvd_next;
    volt_t            res_carrier_reg, res_carrier_next;
    volt_t            res_peak_reg, res_peak_next;
    logic             res_status_reg, res_status_next;
    volt_t            carrier_out_reg, carrier_out_next;
    volt_t            peak_out_reg, peak_out_next;
    logic             status_out_reg, status_out_next;

    // Handshakes
    logic in_fire;
    logic load_out;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign load_out  = (state_reg == S_OUT) && (!m_valid_reg || m_tready);

    // Point memory, entry {unit, index}
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [POINT_W-1:0] ram_rdata;
    point_t            rd_pt;
    logic [31:0]       idx_wide;

    assign idx_wide  = 32'(in_idx);
    assign ram_we    = in_fire && (in_op == OP_WRITE) && (idx_wide < 32'(MAX_POINTS));
    assign ram_waddr = {in_unit, idx_wide[IW-1:0]};
    assign rd_pt     = point_t'(ram_rdata);

    tcti_ram #(
        .WIDTH (POINT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (POINT_W'(in_point)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read address follows the sequencer
    always_comb begin
        unique case (state_reg)
            S_IDLE:  ram_raddr = {in_unit, IW'(0)};
            S_CHK0:  ram_raddr = {unit_reg, last_reg};
            S_CHKL:  ram_raddr = {unit_reg, IW'(1)};
            default: ram_raddr = {unit_reg, pos_reg + IW'(1)};
        endcase
    end

    // Point count of the selected unit, saturated to the table size
    logic [CNT_W-1:0] sel_cnt;
    logic [31:0]      sel_n;

    assign sel_cnt = in_unit ? pts_second_reg : pts_first_reg;
    assign sel_n   = (32'(sel_cnt) > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : 32'(sel_cnt);

    // Segment tests against the point on read data
    logic        in_seg;
    logic [16:0] span_full;
    logic [16:0] dt_full;

    assign in_seg    = (temp_reg >= prev_reg.temp) && (temp_reg <= rd_pt.temp);
    assign span_full = {rd_pt.temp[TEMP_W-1], rd_pt.temp}
                     - {prev_reg.temp[TEMP_W-1], prev_reg.temp};
    assign dt_full   = {temp_reg[TEMP_W-1], temp_reg}
                     - {prev_reg.temp[TEMP_W-1], prev_reg.temp};

    // Shared multiplier: dt * |v1 - v0| for the current lane
    volt_t       v0;
    volt_t       v1;
    logic        dv_neg;
    volt_t       dv_mag;
    logic [31:0] prod;

    assign v0     = lane_reg ? prev_reg.peak : prev_reg.carrier;
    assign v1     = lane_reg ? cur_reg.peak  : cur_reg.carrier;
    assign dv_neg = (v1 < v0);
    assign dv_mag = dv_neg ? (v0 - v1) : (v1 - v0);
    assign prod   = dt_reg * dv_mag;

    // Restoring divider step: remainder stays below span
    logic [16:0] div_shift;
    logic [16:0] div_diff;
    logic        div_ge;
    volt_t       lerp_res;

    assign div_shift = {rem_reg, dvd_reg[VOLT_W-1]};
    assign div_diff  = div_shift - {1'b0, span_reg};
    assign div_ge    = (div_shift >= {1'b0, span_reg});
    assign lerp_res  = neg_reg ? (v0 - dvd_reg) : (v0 + dvd_reg);

    // Sequencer and datapath next state
    always_comb begin
        state_next        = state_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        dflt_carrier_next = dflt_carrier_reg;
        dflt_peak_next    = dflt_peak_reg;
        pts_first_next    = pts_first_reg;
        pts_second_next   = pts_second_reg;
        lane_next         = lane_reg;
        div_cnt_next      = div_cnt_reg;
        unit_next         = unit_reg;
        temp_next         = temp_reg;
        last_next         = last_reg;
        pos_next          = pos_reg;
        prev_next         = prev_reg;
        cur_next          = cur_reg;
        dt_next           = dt_reg;
        span_next         = span_reg;
        neg_next          = neg_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        res_carrier_next  = res_carrier_reg;
        res_peak_next     = res_peak_reg;
        res_status_next   = res_status_reg;
        carrier_out_next  = carrier_out_reg;
        peak_out_next     = peak_out_reg;
        status_out_next   = status_out_reg;

        // Register writes
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEFAULT_CARRIER: dflt_carrier_next = cfg_data;
                REG_DEFAULT_PEAK:    dflt_peak_next    = cfg_data;
                REG_POINTS_FIRST:    pts_first_next    = cfg_data[CNT_W-1:0];
                REG_POINTS_SECOND:   pts_second_next   = cfg_data[CNT_W-1:0];
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire && (in_op == OP_QUERY)) begin
                    unit_next       = in_unit;
                    temp_next       = in_point.temp;
                    last_next       = IW'(sel_n - 32'd1);
                    res_status_next = STATUS_VALID;
                    if (sel_cnt == '0) begin
                        res_carrier_next = dflt_carrier_reg;
                        res_peak_next    = dflt_peak_reg;
                        state_next       = S_OUT;
                    end else begin
                        state_next = S_CHK0;
                    end
                end
            end

            S_CHK0: begin
                prev_next = rd_pt;
                if (temp_reg <= rd_pt.temp) begin
                    res_carrier_next = rd_pt.carrier;
                    res_peak_next    = rd_pt.peak;
                    state_next       = S_OUT;
                end else begin
                    state_next = S_CHKL;
                end
            end

            S_CHKL: begin
                pos_next = IW'(1);
                if (temp_reg >= rd_pt.temp) begin
                    res_carrier_next = rd_pt.carrier;
                    res_peak_next    = rd_pt.peak;
                    state_next       = S_OUT;
                end else begin
                    state_next = S_WALK;
                end
            end

            S_WALK: begin
                if (in_seg) begin
                    if (span_full == '0) begin
                        res_carrier_next = prev_reg.carrier;
                        res_peak_next    = prev_reg.peak;
                        state_next       = S_OUT;
                    end else begin
                        cur_next   = rd_pt;
                        span_next  = span_full[VOLT_W-1:0];
                        dt_next    = dt_full[VOLT_W-1:0];
                        lane_next  = 1'b0;
                        state_next = S_MUL;
                    end
                end else if (pos_reg == last_reg) begin
                    // unsorted table: nothing brackets
                    res_carrier_next = '0;
                    res_peak_next    = '0;
                    res_status_next  = STATUS_NO_SEG;
                    state_next       = S_OUT;
                end else begin
                    prev_next = rd_pt;
                    pos_next  = pos_reg + IW'(1);
                end
            end

            S_MUL: begin
                rem_next     = prod[31:16];
                dvd_next     = prod[15:0];
                neg_next     = dv_neg;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end

            S_DIV: begin
                rem_next     = div_ge ? div_diff[VOLT_W-1:0] : div_shift[VOLT_W-1:0];
                dvd_next     = {dvd_reg[VOLT_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_FIN;
                end
            end

            S_FIN: begin
                if (!lane_reg) begin
                    res_carrier_next = lerp_res;
                    lane_next        = 1'b1;
                    state_next       = S_MUL;
                end else begin
                    res_peak_next = lerp_res;
                    state_next    = S_OUT;
                end
            end

            S_OUT: begin
                if (load_out) begin
                    carrier_out_next = res_carrier_reg;
                    peak_out_next    = res_peak_reg;
                    status_out_next  = res_status_reg;
                    m_valid_next     = 1'b1;
                    state_next       = S_IDLE;
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_valid_reg      <= 1'b0;
            dflt_carrier_reg <= DEFAULT_VOLT_RESET;
            dflt_peak_reg    <= DEFAULT_VOLT_RESET;
            pts_first_reg    <= '0;
            pts_second_reg   <= '0;
            lane_reg         <= 1'b0;
            div_cnt_reg      <= '0;
        end else begin
            state_reg        <= state_next;
            m_valid_reg      <= m_valid_next;
            dflt_carrier_reg <= dflt_carrier_next;
            dflt_peak_reg    <= dflt_peak_next;
            pts_first_reg    <= pts_first_next;
            pts_second_reg   <= pts_second_next;
            lane_reg         <= lane_next;
            div_cnt_reg      <= div_cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        unit_reg        <= unit_next;
        temp_reg        <= temp_next;
        last_reg        <= last_next;
        pos_reg         <= pos_next;
        prev_reg        <= prev_next;
        cur_reg         <= cur_next;
        dt_reg          <= dt_next;
        span_reg        <= span_next;
        neg_reg         <= neg_next;
        rem_reg         <= rem_next;
        dvd_reg         <= dvd_next;
        res_carrier_reg <= res_carrier_next;
        res_peak_reg    <= res_peak_next;
        res_status_reg  <= res_status_next;
        carrier_out_reg <= carrier_out_next;
        peak_out_reg    <= peak_out_next;
        status_out_reg  <= status_out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {peak_out_reg, carrier_out_reg};
    assign m_tuser  = status_out_reg;

endmodule : temp_comp_table_interpolator_unit

`default_nettype wire

// ----- sv/tcti_checker.sv -----
// ============================================================================
// tcti_checker - port-level checks for the interpolator
// Watches the stream ports over time; bound to the top level below.
// ============================================================================
`default_nettype none

module tcti_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [tcti_pkg::S_TUSER_W-1:0]  s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [tcti_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic [tcti_pkg::M_TUSER_W-1:0]  m_tuser
);

    import tcti_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A query transaction keeps the input closed on the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == OP_QUERY) |=> !s_tready)
        else $error("input open right after a query");

    // A write transaction leaves the input open
    a_write_open: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == OP_WRITE) |=> s_tready)
        else $error("input closed after a write");

    // No result appears the cycle after any accepted transaction
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared without processing");

    // An error result carries zero voltages
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] == STATUS_NO_SEG) |-> (m_tdata == '0))
        else $error("error result with nonzero voltages");

endmodule : tcti_checker

bind temp_comp_table_interpolator_unit tcti_checker u_tcti_checker (.*);

`default_nettype wire
